// ===== rtl/vfc_pkg.sv =====
// vfc_pkg: shared types and constants of the vision frame checker
// no dependencies; imported by the interfaces and all rtl modules
`default_nettype none

package vfc_pkg;

    // frame geometry
    localparam int FRAME_LEN = 12;
    localparam int POS_W     = 4;
    localparam int MAG_W     = 15;
    localparam int ERR_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HEAD  = 4'd0;
    localparam logic [POS_W-1:0] POS_FOUND = 4'd1;
    localparam logic [POS_W-1:0] POS_YAW_H = 4'd2;
    localparam logic [POS_W-1:0] POS_YAW_L = 4'd3;
    localparam logic [POS_W-1:0] POS_PIT_H = 4'd4;
    localparam logic [POS_W-1:0] POS_PIT_L = 4'd5;
    localparam logic [POS_W-1:0] POS_SIGN  = 4'd6;
    localparam logic [POS_W-1:0] POS_LAST_SUMMED = 4'd7;
    localparam logic [POS_W-1:0] POS_CHK   = 4'd8;
    localparam logic [POS_W-1:0] POS_TAIL  = 4'd11;

    // result status codes
    localparam logic [1:0] STAT_FOUND     = 2'd0;
    localparam logic [1:0] STAT_NO_TARGET = 2'd1;
    localparam logic [1:0] STAT_BAD_FRAME = 2'd2;
    localparam logic [1:0] STAT_BAD_SUM   = 2'd3;

    // sign quadrant codes
    localparam logic [7:0] SIGN_YN_PN = 8'd1;
    localparam logic [7:0] SIGN_YP_PN = 8'd2;
    localparam logic [7:0] SIGN_YP_PP = 8'd3;
    localparam logic [7:0] SIGN_YN_PP = 8'd4;

    localparam logic [7:0] TARGET_FLAG = 8'd1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT = 2'd2;

    localparam logic [7:0]       HEADER_RESET    = 8'hAA;
    localparam logic [7:0]       TAIL_RESET      = 8'h54;
    localparam logic [MAG_W-1:0] YAW_LIMIT_RESET = 15'd200;

    // summary of one complete frame, handed from assembler to evaluator
    typedef struct packed {
        logic [7:0]       head;
        logic [7:0]       tail;
        logic             chk_ok;
        logic             found;
        logic [MAG_W-1:0] yaw_mag;
        logic [MAG_W-1:0] pitch_mag;
        logic [7:0]       sign_code;
    } frame_t;

endpackage

`default_nettype wire

// ===== rtl/vfc_if.sv =====
// vfc_if: channel interfaces of the vision frame checker
// byte input, result output and register write; depends on vfc_pkg
`default_nettype none

interface vfc_byte_if import vfc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       frame_start;

    modport source (output valid, output byte_value, output frame_start, input ready);
    modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

interface vfc_result_if import vfc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [ERR_W-1:0] yaw_error;
    logic signed [ERR_W-1:0] pitch_error;

    modport source (output valid, output status, output yaw_error, output pitch_error,
                    input ready);
    modport sink   (input valid, input status, input yaw_error, input pitch_error,
                    output ready);
endinterface

interface vfc_cfg_if import vfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/vfc_collect.sv =====
// vfc_collect: frame assembler, tracks byte position and folds bytes into a summary
// depends on vfc_pkg; feeds vfc_eval
`default_nettype none

module vfc_collect import vfc_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_value,
    input  wire logic       frame_start,
    output logic            frame_valid,
    output frame_t          frame,
    input  wire logic       frame_take
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             frame_valid_reg, frame_valid_next;
    frame_t           frame_reg, frame_next;

    logic [7:0]       head_reg, head_next;
    logic [7:0]       sum_reg, sum_next;
    logic             chk_ok_reg, chk_ok_next;
    logic             found_reg, found_next;
    logic [7:0]       hi_reg, hi_next;
    logic [MAG_W-1:0] yaw_mag_reg, yaw_mag_next;
    logic [MAG_W-1:0] pitch_mag_reg, pitch_mag_next;
    logic [7:0]       sign_reg, sign_next;

    logic             accept;
    logic [POS_W-1:0] idx;
    logic [MAG_W-1:0] mag;

    assign in_ready    = !frame_valid_reg || frame_take;
    assign accept      = in_valid && in_ready;
    assign idx         = frame_start ? POS_HEAD : pos_reg;
    assign mag         = MAG_W'(hi_reg) * MAG_W'(100) + MAG_W'(byte_value);
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    always_comb
    begin
        pos_next         = pos_reg;
        frame_valid_next = frame_valid_reg;
        frame_next       = frame_reg;
        head_next        = head_reg;
        sum_next         = sum_reg;
        chk_ok_next      = chk_ok_reg;
        found_next       = found_reg;
        hi_next          = hi_reg;
        yaw_mag_next     = yaw_mag_reg;
        pitch_mag_next   = pitch_mag_reg;
        sign_next        = sign_reg;

        if (frame_take)
        begin
            frame_valid_next = 1'b0;
        end

        if (accept)
        begin
            // running checksum over bytes one to seven
            if (idx == POS_HEAD)
            begin
                sum_next = 8'd0;
            end
            else if (idx <= POS_LAST_SUMMED)
            begin
                sum_next = sum_reg + byte_value;
            end

            case (idx)
                POS_HEAD:  head_next      = byte_value;
                POS_FOUND: found_next     = (byte_value == TARGET_FLAG);
                POS_YAW_H: hi_next        = byte_value;
                POS_YAW_L: yaw_mag_next   = mag;
                POS_PIT_H: hi_next        = byte_value;
                POS_PIT_L: pitch_mag_next = mag;
                POS_SIGN:  sign_next      = byte_value;
                POS_CHK:   chk_ok_next    = (sum_reg == byte_value);
                default:   ;
            endcase

            if (idx == POS_TAIL)
            begin
                pos_next             = POS_HEAD;
                frame_valid_next     = 1'b1;
                frame_next.head      = head_reg;
                frame_next.tail      = byte_value;
                frame_next.chk_ok    = chk_ok_reg;
                frame_next.found     = found_reg;
                frame_next.yaw_mag   = yaw_mag_reg;
                frame_next.pitch_mag = pitch_mag_reg;
                frame_next.sign_code = sign_reg;
            end
            else
            begin
                pos_next = idx + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_HEAD;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        head_reg      <= head_next;
        sum_reg       <= sum_next;
        chk_ok_reg    <= chk_ok_next;
        found_reg     <= found_next;
        hi_reg        <= hi_next;
        yaw_mag_reg   <= yaw_mag_next;
        pitch_mag_reg <= pitch_mag_next;
        sign_reg      <= sign_next;
    end

endmodule

`default_nettype wire

// ===== rtl/vfc_eval.sv =====
// vfc_eval: frame evaluator, status decode, sign selection, yaw clamp, result register
// depends on vfc_pkg; fed by vfc_collect
`default_nettype none

module vfc_eval import vfc_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    frame_valid,
    input  wire frame_t                  frame,
    output logic                         frame_take,
    input  wire logic [7:0]              header_byte,
    input  wire logic [7:0]              tail_byte,
    input  wire logic [MAG_W-1:0]        yaw_limit,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   status,
    output logic signed [ERR_W-1:0]      yaw_error,
    output logic signed [ERR_W-1:0]      pitch_error
);

    logic signed [ERR_W-1:0] last_yaw_reg, last_yaw_next;
    logic signed [ERR_W-1:0] last_pitch_reg, last_pitch_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic signed [ERR_W-1:0] yaw_reg, yaw_next;
    logic signed [ERR_W-1:0] pitch_reg, pitch_next;

    logic [1:0]              stat;
    logic signed [ERR_W-1:0] yaw_pos, pitch_pos, yaw_sel, pitch_sel, lim, yaw_clamped;

    assign frame_take = frame_valid && (!out_valid_reg || out_ready);
    assign yaw_pos    = signed'({1'b0, frame.yaw_mag});
    assign pitch_pos  = signed'({1'b0, frame.pitch_mag});
    assign lim        = signed'({1'b0, yaw_limit});

    always_comb
    begin
        if (frame.head != header_byte || frame.tail != tail_byte)
        begin
            stat = STAT_BAD_FRAME;
        end
        else if (!frame.chk_ok)
        begin
            stat = STAT_BAD_SUM;
        end
        else if (!frame.found)
        begin
            stat = STAT_NO_TARGET;
        end
        else
        begin
            stat = STAT_FOUND;
        end

        // unknown quadrant keeps the previous signed values
        case (frame.sign_code)
            SIGN_YN_PN:
            begin
                yaw_sel   = -yaw_pos;
                pitch_sel = -pitch_pos;
            end
            SIGN_YP_PN:
            begin
                yaw_sel   = yaw_pos;
                pitch_sel = -pitch_pos;
            end
            SIGN_YP_PP:
            begin
                yaw_sel   = yaw_pos;
                pitch_sel = pitch_pos;
            end
            SIGN_YN_PP:
            begin
                yaw_sel   = -yaw_pos;
                pitch_sel = pitch_pos;
            end
            default:
            begin
                yaw_sel   = last_yaw_reg;
                pitch_sel = last_pitch_reg;
            end
        endcase

        if (yaw_sel > lim)
        begin
            yaw_clamped = lim;
        end
        else if (yaw_sel < -lim)
        begin
            yaw_clamped = -lim;
        end
        else
        begin
            yaw_clamped = yaw_sel;
        end
    end

    always_comb
    begin
        last_yaw_next   = last_yaw_reg;
        last_pitch_next = last_pitch_reg;
        status_next     = status_reg;
        yaw_next        = yaw_reg;
        pitch_next      = pitch_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (frame_take)
        begin
            out_valid_next = 1'b1;
            status_next    = stat;
            if (stat == STAT_FOUND)
            begin
                last_yaw_next   = yaw_sel;
                last_pitch_next = pitch_sel;
                yaw_next        = yaw_clamped;
                pitch_next      = pitch_sel;
            end
            else
            begin
                yaw_next   = '0;
                pitch_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            last_yaw_reg   <= '0;
            last_pitch_reg <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            last_yaw_reg   <= last_yaw_next;
            last_pitch_reg <= last_pitch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        yaw_reg    <= yaw_next;
        pitch_reg  <= pitch_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign yaw_error   = yaw_reg;
    assign pitch_error = pitch_reg;

endmodule

`default_nettype wire

// ===== rtl/vision_frame_checker.sv =====
// vision_frame_checker: checks 12-byte target frames and reports status, yaw and pitch
// throughput one byte transfer per clock unless the input stalls; the result passes from the
// frame register, written at the transfer of the twelfth byte, to the result register
// byte input stalls only while a finished frame waits behind a result not yet taken
// reset (rst_n, asynchronous, active low) clears byte position, pending frame, result
// valid and last signed values; registers return to header 0xaa, tail 0x54, limit 200
// depends on vfc_pkg, vfc_if, vfc_collect and vfc_eval
`default_nettype none

module vision_frame_checker import vfc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    vfc_byte_if.sink      byte_in,
    vfc_result_if.source  result_out,
    vfc_cfg_if.sink       cfg
);

    // configuration registers
    logic [7:0]       header_reg, header_next;
    logic [7:0]       tail_reg, tail_next;
    logic [MAG_W-1:0] yaw_limit_reg, yaw_limit_next;

    // assembler to evaluator
    logic   frame_valid;
    logic   frame_take;
    frame_t frame;

    // register writes are always taken; an index beyond the list is dropped
    assign cfg.ready = 1'b1;

    always_comb
    begin
        header_next    = header_reg;
        tail_next      = tail_reg;
        yaw_limit_next = yaw_limit_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER:    header_next    = cfg.data[7:0];
                REG_TAIL:      tail_next      = cfg.data[7:0];
                REG_YAW_LIMIT: yaw_limit_next = cfg.data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= HEADER_RESET;
            tail_reg      <= TAIL_RESET;
            yaw_limit_reg <= YAW_LIMIT_RESET;
        end
        else
        begin
            header_reg    <= header_next;
            tail_reg      <= tail_next;
            yaw_limit_reg <= yaw_limit_next;
        end
    end

    // byte position tracking and per-byte folding: magnitudes, checksum, flags
    vfc_collect u_collect (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (byte_in.valid),
        .in_ready    (byte_in.ready),
        .byte_value  (byte_in.byte_value),
        .frame_start (byte_in.frame_start),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take)
    );

    // header and tail check against the current registers, sign and clamp,
    // output register that holds a result while the next frame is collected
    vfc_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_take  (frame_take),
        .header_byte (header_reg),
        .tail_byte   (tail_reg),
        .yaw_limit   (yaw_limit_reg),
        .out_valid   (result_out.valid),
        .out_ready   (result_out.ready),
        .status      (result_out.status),
        .yaw_error   (result_out.yaw_error),
        .pitch_error (result_out.pitch_error)
    );

endmodule

`default_nettype wire
